### rtl/core/ntwa_pkg.sv
// Shared request codes, constants and chain types of the neighbor table.
package ntwa_pkg;

	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_PURGE = 2'd1;
	localparam logic [1:0] REQ_AVG   = 2'd2;

	localparam int ADDR_W   = 31;
	localparam int SIG_W    = 16;
	localparam int TICK_W   = 32;
	localparam int SLOT_W   = 4;
	localparam int DROP_W   = 5;
	localparam int S_DATA_W = 80;
	localparam int M_DATA_W = 32;

	localparam logic [TICK_W-1:0] AGE_LIMIT_RST = 32'd1000000;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ADDR_W-1:0] addr;
		logic [SIG_W-1:0]  sig;
		logic [TICK_W-1:0] now;
		logic [TICK_W-1:0] limit;
	} req_bc_t;

	typedef struct packed {
		logic v;
		logic hit;
		logic tgt_ok;
	} scan_flags_t;

endpackage

### rtl/core/ntwa_cell.sv
// One table entry of the neighbor chain with its slice of the scan token.
module ntwa_cell
	import ntwa_pkg::*;
#(
	parameter int DEPTH    = 16,
	parameter int CELL_IDX = 0
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  req_bc_t                                    req,
	input  logic                                       wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_idx,
	input  scan_flags_t                                flg_in,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] tgt_in,
	input  logic [$clog2(DEPTH+1)-1:0]                 drop_in,
	input  logic [SIG_W+$clog2(DEPTH+1)-1:0]           sum_in,
	input  logic [$clog2(DEPTH+1)-1:0]                 cnt_in,
	output scan_flags_t                                flg_out,
	output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] tgt_out,
	output logic [$clog2(DEPTH+1)-1:0]                 drop_out,
	output logic [SIG_W+$clog2(DEPTH+1)-1:0]           sum_out,
	output logic [$clog2(DEPTH+1)-1:0]                 cnt_out
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);
	localparam int SUM_W = SIG_W + CNT_W;
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic              valid_q;
	logic [ADDR_W-1:0] addr_q;
	logic [TICK_W-1:0] stamp_q;
	logic [SIG_W-1:0]  sig_q;

	scan_flags_t       flg_n;
	logic [IDX_W-1:0]  tgt_n;
	logic [CNT_W-1:0]  drop_n;
	logic [SUM_W-1:0]  sum_n;
	logic [CNT_W-1:0]  cnt_n;
	logic              match;
	logic              expired;
	logic              expire;
	logic              wr_hit;

	assign wr_hit  = wr_en && (wr_idx == MY_IDX);
	assign match   = valid_q && (addr_q == req.addr);
	assign expired = valid_q &&
		(({1'b0, stamp_q} + {1'b0, req.limit}) < {1'b0, req.now});

	always_comb begin
		flg_n  = flg_in;
		tgt_n  = tgt_in;
		drop_n = drop_in;
		sum_n  = sum_in;
		cnt_n  = cnt_in;
		expire = 1'b0;
		if (flg_in.v) begin
			case (req.kind)
				REQ_ADD: begin
					if (!flg_in.hit) begin
						if (match) begin
							flg_n.hit    = 1'b1;
							flg_n.tgt_ok = 1'b1;
							tgt_n        = MY_IDX;
						end else if (!valid_q && !flg_in.tgt_ok) begin
							flg_n.tgt_ok = 1'b1;
							tgt_n        = MY_IDX;
						end
					end
				end
				REQ_PURGE: begin
					if (expired) begin
						expire = 1'b1;
						drop_n = drop_in + CNT_W'(1);
					end
				end
				REQ_AVG: begin
					if (valid_q) begin
						sum_n = sum_in + {{(SUM_W-SIG_W){sig_q[SIG_W-1]}}, sig_q};
						cnt_n = cnt_in + CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			flg_out   <= '0;
		end else begin
			flg_out <= flg_n;
			if (wr_hit) begin
				valid_q <= 1'b1;
			end else if (expire) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tgt_out  <= tgt_n;
		drop_out <= drop_n;
		sum_out  <= sum_n;
		cnt_out  <= cnt_n;
		if (wr_hit) begin
			addr_q  <= req.addr;
			stamp_q <= req.now;
			sig_q   <= req.sig;
		end
	end

endmodule

### rtl/core/ntwa_div.sv
// Iterative signed-by-unsigned divider for the mean signal level.
module ntwa_div
	import ntwa_pkg::*;
#(
	parameter int NUM_W = 21,
	parameter int DEN_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [SIG_W-1:0] quo
);

	localparam int STEP_W = $clog2(NUM_W+1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [NUM_W-1:0]  quo_q;
	logic              neg_q;

	logic [DEN_W:0]    trial;
	logic              take;
	logic [NUM_W-1:0]  mag;
	logic [NUM_W-1:0]  signed_quo;

	assign mag        = num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
	assign trial      = {rem_q, quo_q[NUM_W-1]};
	assign take       = trial >= {1'b0, den_q};
	assign signed_quo = neg_q ? (~quo_q + NUM_W'(1)) : quo_q;
	assign quo        = signed_quo[SIG_W-1:0];
	assign done       = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(NUM_W-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= mag;
			neg_q <= num[NUM_W-1];
		end else if (busy_q) begin
			rem_q <= take ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], take};
		end
	end

endmodule

### rtl/core/neighbor_table_with_aging_core.sv
// Top level of the neighbor table with timeout aging.
//
// Requests arrive on the s_ stream: tuser carries the request kind (add or
// refresh, purge expired, average query), tdata the address, signal level
// and current time. Each request yields one result transaction on the m_
// stream. cfg_wr_en/cfg_wr_data set the age limit; the user must write it
// only while the block is idle, which the block itself does not enforce.
// A request is taken only when no earlier request is still in process;
// a result waiting in the output register does not block the next request.
// A scan token walks the chain of TABLE_DEPTH entry cells, one cell per
// cycle; an average over a non-empty table then adds the serial divider,
// one quotient bit per cycle, before its result is loaded.
// A stalled receiver holds the result in the output register; a finished
// request then waits there before its result is loaded.
// Reset clears all entry valid marks, restores the age limit to 1000000
// and empties the output register.
module neighbor_table_with_aging_core
	import ntwa_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [TICK_W-1:0]   cfg_wr_data,
	input  logic                s_tvalid,
	output logic                s_tready,
	// node_address[30:0], signal_level[46:31], now_ticks[78:47], zero[79]
	input  logic [S_DATA_W-1:0] s_tdata,
	// req_type[1:0]
	input  logic [1:0]          s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// slot[3:0], found[4], full_res[5], dropped_count[10:6],
	// mean_signal[26:11], mean_valid[27], zero[31:28]
	output logic [M_DATA_W-1:0] m_tdata
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH+1);
	localparam int SUM_W = SIG_W + CNT_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_PUT  = 2'd3;

	logic [1:0]        state_q;
	logic              launch_q;
	logic [TICK_W-1:0] age_limit_q;
	logic [1:0]        kind_q;
	logic [ADDR_W-1:0] addr_q;
	logic [SIG_W-1:0]  sig_q;
	logic [TICK_W-1:0] now_q;

	logic [SLOT_W-1:0] res_slot_q;
	logic              res_found_q;
	logic              res_full_q;
	logic [DROP_W-1:0] res_drop_q;
	logic [SIG_W-1:0]  res_mean_q;
	logic              res_mvalid_q;

	logic                m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	req_bc_t     req;
	scan_flags_t flg  [0:TABLE_DEPTH];
	logic [IDX_W-1:0] tgt  [0:TABLE_DEPTH];
	logic [CNT_W-1:0] drop [0:TABLE_DEPTH];
	logic [SUM_W-1:0] sum  [0:TABLE_DEPTH];
	logic [CNT_W-1:0] cnt  [0:TABLE_DEPTH];

	logic             s_fire;
	logic             scan_end;
	logic             wr_en;
	logic             div_start;
	logic             div_done;
	logic [SIG_W-1:0] div_quo;
	logic             out_free;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_fire    = s_tvalid && s_tready;
	assign scan_end  = (state_q == ST_SCAN) && flg[TABLE_DEPTH].v;
	assign wr_en     = scan_end && (kind_q == REQ_ADD) && flg[TABLE_DEPTH].tgt_ok;
	assign div_start = scan_end && (kind_q == REQ_AVG) && (cnt[TABLE_DEPTH] != '0);
	assign out_free  = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	assign req.kind  = kind_q;
	assign req.addr  = addr_q;
	assign req.sig   = sig_q;
	assign req.now   = now_q;
	assign req.limit = age_limit_q;

	assign flg[0].v      = launch_q;
	assign flg[0].hit    = 1'b0;
	assign flg[0].tgt_ok = 1'b0;
	assign tgt[0]        = '0;
	assign drop[0]       = '0;
	assign sum[0]        = '0;
	assign cnt[0]        = '0;

	for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
		ntwa_cell #(
			.DEPTH   (TABLE_DEPTH),
			.CELL_IDX(gi)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.req     (req),
			.wr_en   (wr_en),
			.wr_idx  (tgt[TABLE_DEPTH]),
			.flg_in  (flg[gi]),
			.tgt_in  (tgt[gi]),
			.drop_in (drop[gi]),
			.sum_in  (sum[gi]),
			.cnt_in  (cnt[gi]),
			.flg_out (flg[gi+1]),
			.tgt_out (tgt[gi+1]),
			.drop_out(drop[gi+1]),
			.sum_out (sum[gi+1]),
			.cnt_out (cnt[gi+1])
		);
	end

	ntwa_div #(
		.NUM_W(SUM_W),
		.DEN_W(CNT_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (sum[TABLE_DEPTH]),
		.den   (cnt[TABLE_DEPTH]),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			launch_q    <= 1'b0;
			age_limit_q <= AGE_LIMIT_RST;
			m_tvalid_q  <= 1'b0;
		end else begin
			launch_q <= s_fire;
			if (cfg_wr_en) begin
				age_limit_q <= cfg_wr_data;
			end
			if ((state_q == ST_PUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						state_q <= div_start ? ST_DIV : ST_PUT;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			kind_q <= s_tuser;
			addr_q <= s_tdata[30:0];
			sig_q  <= s_tdata[46:31];
			now_q  <= s_tdata[78:47];
		end
		if (scan_end) begin
			res_mean_q   <= '0;
			res_mvalid_q <= 1'b0;
			case (kind_q)
				REQ_ADD: begin
					res_slot_q  <= flg[TABLE_DEPTH].tgt_ok ? SLOT_W'(tgt[TABLE_DEPTH]) : '0;
					res_found_q <= flg[TABLE_DEPTH].hit;
					res_full_q  <= !flg[TABLE_DEPTH].tgt_ok;
					res_drop_q  <= '0;
				end
				REQ_PURGE: begin
					res_slot_q  <= '0;
					res_found_q <= 1'b0;
					res_full_q  <= 1'b0;
					res_drop_q  <= DROP_W'(drop[TABLE_DEPTH]);
				end
				default: begin
					res_slot_q  <= '0;
					res_found_q <= 1'b0;
					res_full_q  <= 1'b0;
					res_drop_q  <= '0;
				end
			endcase
		end else if ((state_q == ST_DIV) && div_done) begin
			res_mean_q   <= div_quo;
			res_mvalid_q <= 1'b1;
		end
		if ((state_q == ST_PUT) && out_free) begin
			m_tdata_q <= {4'b0, res_mvalid_q, res_mean_q, res_drop_q,
				res_full_q, res_found_q, res_slot_q};
		end
	end

endmodule

### bench/tb_top.sv
// Self-checking testbench for the neighbor table with timeout aging.
module tb_top
	import ntwa_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              found;
		logic              full_res;
		logic [DROP_W-1:0] dropped;
		logic [SIG_W-1:0]  mean;
		logic              mean_valid;
	} table_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [TICK_W-1:0]   cfg_wr_data = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [1:0]          s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	logic                tbl_valid [DEPTH];
	logic [ADDR_W-1:0]   tbl_addr [DEPTH];
	logic [TICK_W-1:0]   tbl_stamp [DEPTH];
	logic signed [SIG_W-1:0] tbl_sig [DEPTH];
	logic [TICK_W-1:0]   age_limit_now = AGE_LIMIT_RST;
	logic [TICK_W-1:0]   tick_now = '0;

	table_result_t       pending_results [$];
	int                  mismatch_count = 0;
	int                  send_idle_pct = 21;
	int                  recv_idle_pct = 53;

	neighbor_table_with_aging_core #(
		.TABLE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	function automatic table_result_t table_predict(input logic [1:0] kind,
			input logic [ADDR_W-1:0] addr, input logic [SIG_W-1:0] sig,
			input logic [TICK_W-1:0] now);
		table_result_t r;
		int target;
		logic hit;
		longint total;
		longint count;
		longint mean;
		r = '0;
		target = -1;
		hit = 1'b0;
		total = 0;
		count = 0;
		case (kind)
			REQ_ADD: begin
				for (int i = 0; i < DEPTH; i++) begin
					if (tbl_valid[i] && tbl_addr[i] == addr) begin
						target = i;
						hit = 1'b1;
						break;
					end
					if (!tbl_valid[i] && target < 0)
						target = i;
				end
				if (target < 0) begin
					r.full_res = 1'b1;
				end else begin
					tbl_valid[target] = 1'b1;
					tbl_addr[target] = addr;
					tbl_stamp[target] = now;
					tbl_sig[target] = sig;
					r.slot = target[SLOT_W-1:0];
					r.found = hit;
				end
			end
			REQ_PURGE: begin
				for (int i = 0; i < DEPTH; i++) begin
					if (tbl_valid[i] &&
							({1'b0, tbl_stamp[i]} + {1'b0, age_limit_now}) < {1'b0, now}) begin
						tbl_valid[i] = 1'b0;
						count++;
					end
				end
				r.dropped = count[DROP_W-1:0];
			end
			REQ_AVG: begin
				for (int i = 0; i < DEPTH; i++) begin
					if (tbl_valid[i]) begin
						total += tbl_sig[i];
						count++;
					end
				end
				if (count != 0) begin
					mean = total / count;
					r.mean = mean[SIG_W-1:0];
					r.mean_valid = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk) begin : result_check
		table_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected, data %h", m_tdata));
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[3:0] != want.slot)
					report_mismatch($sformatf("slot %0d, want %0d", m_tdata[3:0], want.slot));
				if (m_tdata[4] != want.found)
					report_mismatch($sformatf("found %0b, want %0b", m_tdata[4], want.found));
				if (m_tdata[5] != want.full_res)
					report_mismatch($sformatf("full_res %0b, want %0b", m_tdata[5],
						want.full_res));
				if (m_tdata[10:6] != want.dropped)
					report_mismatch($sformatf("dropped_count %0d, want %0d", m_tdata[10:6],
						want.dropped));
				if (m_tdata[26:11] != want.mean)
					report_mismatch($sformatf("mean_signal %0d, want %0d",
						$signed(m_tdata[26:11]), $signed(want.mean)));
				if (m_tdata[27] != want.mean_valid)
					report_mismatch($sformatf("mean_valid %0b, want %0b", m_tdata[27],
						want.mean_valid));
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_request(input logic [1:0] kind, input logic [ADDR_W-1:0] addr,
			input logic [SIG_W-1:0] sig, input logic [TICK_W-1:0] now);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, now, sig, addr};
		s_tuser <= kind;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(table_predict(kind, addr, sig, now));
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic set_age_limit(input logic [TICK_W-1:0] value);
		drain_results();
		repeat (50) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		age_limit_now = value;
	endtask

	task automatic test_empty_table();
		send_request(REQ_AVG, '0, '0, '0);
		send_request(REQ_PURGE, '0, '0, 32'hFFFF_FFFF);
		send_request(REQ_UNUSED, 31'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
	endtask

	task automatic test_fill_and_refresh();
		send_request(REQ_ADD, 31'h0, 16'h8000, 32'h0);
		send_request(REQ_ADD, 31'h7FFF_FFFF, 16'h7FFF, 32'hFFFF_FFFF);
		send_request(REQ_ADD, 31'h0, 16'hFFFF, 32'd5);
		for (int i = 0; i < DEPTH - 2; i++)
			send_request(REQ_ADD, 31'h2AAA_AA00 + ADDR_W'(i), 16'hFFF9, 32'd10 + i);
		send_request(REQ_ADD, 31'h5555_5555, 16'h1234, 32'd100);
		send_request(REQ_AVG, '0, '0, '0);
	endtask

	task automatic test_age_limits();
		set_age_limit('0);
		send_request(REQ_PURGE, '0, '0, 32'hFFFF_FFFF);
		set_age_limit(32'hFFFF_FFFF);
		send_request(REQ_ADD, 31'd9, 16'hFFFD, 32'h0);
		send_request(REQ_PURGE, '0, '0, 32'hFFFF_FFFF);
		set_age_limit(32'd1);
		send_request(REQ_PURGE, '0, '0, 32'd2);
		send_request(REQ_AVG, '0, '0, '0);
	endtask

	task automatic test_random_traffic(input int count, input int s_pct, input int r_pct,
			input logic [TICK_W-1:0] limit, input int step_max);
		logic [ADDR_W-1:0] pool [20];
		logic [ADDR_W-1:0] addr;
		logic [SIG_W-1:0] sig;
		logic [1:0] kind;
		int pick;
		set_age_limit(limit);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		foreach (pool[i])
			pool[i] = ADDR_W'($urandom());
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			kind = (pick < 55) ? REQ_ADD : (pick < 75) ? REQ_PURGE :
				(pick < 95) ? REQ_AVG : REQ_UNUSED;
			addr = ($urandom_range(99) < 85) ? pool[$urandom_range(19)] :
				ADDR_W'($urandom());
			case ($urandom_range(19))
				0: sig = 16'h8000;
				1: sig = 16'h7FFF;
				2: sig = 16'hFFFF;
				default: sig = SIG_W'($urandom());
			endcase
			if ($urandom_range(99) < 3)
				tick_now = $urandom();
			else
				tick_now = tick_now + $urandom_range(step_max);
			send_request(kind, addr, sig, tick_now);
			if (n % 150 == 149)
				drain_results();
		end
	endtask

	initial begin
		foreach (tbl_valid[i]) begin
			tbl_valid[i] = 1'b0;
			tbl_addr[i] = '0;
			tbl_stamp[i] = '0;
			tbl_sig[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_fill_and_refresh();
		test_age_limits();
		test_random_traffic(570, 21, 53, 32'd400, 40);
		test_random_traffic(570, 53, 21, 32'd5000, 60);
		test_random_traffic(570, 0, 0, 32'd64, 16);
		s_tvalid <= 1'b0;
		for (int w = 0; w < 20000 && pending_results.size() != 0; w++)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### filelist.f
rtl/core/ntwa_pkg.sv
rtl/core/ntwa_cell.sv
rtl/core/ntwa_div.sv
rtl/core/neighbor_table_with_aging_core.sv
bench/tb_top.sv
